FILE: hw/rtl/rahh_pkg.sv
package rahh_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SCAN_W      = IDX_W + 1;

  localparam int ROW_W   = 32;
  localparam int COUNT_W = 32;
  localparam int THR_W   = 16;

  localparam logic [THR_W-1:0]   THR_RESET     = 16'd1000;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
  localparam logic [THR_W-1:0]   BONUS_DIVISOR = 16'd58;

  // The bonus quotient floor(n / 58) is taken as floor((n >> 1) / 29), and the division
  // by 29 as a multiplication by ceil(2^36 / 29) and a shift, exact for any 31-bit value.
  localparam int                 RECIP_W     = 32;
  localparam logic [RECIP_W-1:0] BONUS_RECIP = 32'd2369637129;
  localparam int                 BONUS_SHIFT = 36;
  localparam int                 PROD_W      = COUNT_W - 1 + RECIP_W;

  localparam logic OP_ACCESS       = 1'b0;
  localparam logic OP_WINDOW_RESET = 1'b1;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COUNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] dividend;
    logic [THR_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [THR_W-1:0]   remainder;
  } div_rsp_t;

endpackage

FILE: hw/rtl/rahh_if.sv
interface rahh_access_if;
  import rahh_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic [ROW_W-1:0] row_addr;

  modport source (output valid, output operation, output row_addr, input ready);
  modport sink   (input valid, input operation, input row_addr, output ready);
endinterface

interface rahh_result_if;
  logic valid;
  logic ready;
  logic mitigate;

  modport source (output valid, output mitigate, input ready);
  modport sink   (input valid, input mitigate, output ready);
endinterface

FILE: hw/rtl/rahh_ram.sv
module rahh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/rahh_div.sv
module rahh_div (
  input  logic                clk,
  input  logic                rst,
  input  rahh_pkg::div_req_t  req,
  output rahh_pkg::div_rsp_t  rsp
);
  import rahh_pkg::*;

  localparam int STEP_W = $clog2(COUNT_W);

  logic               busy;
  logic               done;
  logic [STEP_W-1:0]  step;
  logic [COUNT_W-1:0] quo;
  logic [THR_W-1:0]   rem;
  logic [THR_W-1:0]   divisor;

  logic [THR_W:0]     trial;
  logic               fits;

  // Restoring division, one quotient bit per cycle, most significant first.
  always_comb begin
    trial = {rem, quo[COUNT_W-1]};
    fits  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(COUNT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      quo <= {quo[COUNT_W-2:0], fits};
      rem <= fits ? THR_W'(trial - {1'b0, divisor}) : trial[THR_W-1:0];
    end else if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

FILE: hw/rtl/row_activation_heavy_hitter_tracker_top.sv
// Sequence: a row activation scans the table through the single read port, then computes
// the bonus and runs the threshold division; a zero threshold skips the division, and an
// activation that only moves the spillover counter skips both; a window reset goes straight
// to its result. Only one item is in flight at a time.
// Reset clears the valid bits, the spillover counter and the output; threshold = 1000.
module row_activation_heavy_hitter_tracker_top (
  input  logic                      clk,
  input  logic                      rst,
  rahh_access_if.sink               access,
  rahh_result_if.source             result,
  input  logic                      cfg_we,
  input  logic [rahh_pkg::THR_W-1:0] cfg_wdata
);
  import rahh_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_DECIDE = 7'b0000100,
    S_MUL    = 7'b0001000,
    S_BONUS  = 7'b0010000,
    S_CHECK  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state;

  logic [THR_W-1:0]       threshold;
  logic [TABLE_DEPTH-1:0] valid;
  logic [COUNT_W-1:0]     spill;

  logic [ROW_W-1:0]   row_q;
  logic [SCAN_W-1:0]  scan_cnt;
  logic               rd_pend;
  logic [IDX_W-1:0]   rd_idx;

  logic               m_found;
  logic [IDX_W-1:0]   m_idx;
  logic [COUNT_W-1:0] m_cnt;
  logic               i_found;
  logic [IDX_W-1:0]   i_idx;
  logic               s_found;
  logic [IDX_W-1:0]   s_idx;

  logic [IDX_W-1:0]   slot_q;
  logic [COUNT_W-1:0] n_q;
  logic [PROD_W-1:0]  prod_q;
  logic [COUNT_W-1:0] newc_q;
  logic               mit_q;

  logic               out_valid;
  logic               out_mitigate;

  entry_t             rd_entry;
  entry_t             wr_entry;
  logic               ram_we;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               take;
  logic               rd_valid;
  logic               hit;
  logic               any_slot;
  logic [IDX_W-1:0]   slot_sel;
  logic [COUNT_W-1:0] base;
  logic [COUNT_W-1:0] n_next;
  logic [COUNT_W-1:0] bonus_q;
  logic [COUNT_W:0]   bonus_sum;
  logic [COUNT_W-1:0] newc_next;
  logic               out_free;

  assign take     = access.valid && access.ready;
  assign out_free = !out_valid || result.ready;
  assign rd_valid = valid[rd_idx];
  assign hit      = rd_pend && rd_valid && (rd_entry.row == row_q);

  always_comb begin
    any_slot = m_found || i_found || s_found;
    if (m_found) begin
      slot_sel = m_idx;
      base     = m_cnt;
    end else if (i_found) begin
      slot_sel = i_idx;
      base     = '0;
    end else begin
      slot_sel = s_idx;
      base     = spill;
    end
    n_next    = (base == COUNT_MAX) ? COUNT_MAX : base + COUNT_W'(1);
    bonus_q   = COUNT_W'(prod_q[PROD_W-1:BONUS_SHIFT]);
    bonus_sum = {1'b0, n_q} + {bonus_q, 1'b0};
    newc_next = bonus_sum[COUNT_W] ? COUNT_MAX : bonus_sum[COUNT_W-1:0];
  end

  always_comb begin
    div_req.start    = (state == S_BONUS) && (threshold != '0);
    div_req.dividend = newc_next;
    div_req.divisor  = threshold;
  end

  assign ram_we         = (state == S_BONUS);
  assign wr_entry.row   = row_q;
  assign wr_entry.count = newc_next;

  rahh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_q),
    .wdata (wr_entry),
    .raddr (scan_cnt[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  rahh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Only one item is in flight, so a table write never overlaps a scan read.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      spill     <= '0;
      rd_pend   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            rd_pend <= 1'b0;
            if (access.operation == OP_WINDOW_RESET) begin
              valid <= '0;
              spill <= '0;
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_pend <= (scan_cnt != SCAN_W'(TABLE_DEPTH));
          if (rd_pend && rd_idx == IDX_W'(TABLE_DEPTH - 1)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!any_slot) begin
            if (spill != COUNT_MAX) begin
              spill <= spill + COUNT_W'(1);
            end
            state <= S_FINISH;
          end else begin
            if (!m_found && i_found) begin
              valid[i_idx] <= 1'b1;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_BONUS;
        end
        S_BONUS: begin
          state <= (threshold == '0) ? S_FINISH : S_CHECK;
        end
        S_CHECK: begin
          if (div_rsp.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        row_q    <= access.row_addr;
        scan_cnt <= '0;
        m_found  <= 1'b0;
        i_found  <= 1'b0;
        s_found  <= 1'b0;
        mit_q    <= 1'b0;
      end
      S_SCAN: begin
        if (scan_cnt != SCAN_W'(TABLE_DEPTH)) begin
          scan_cnt <= scan_cnt + SCAN_W'(1);
        end
        rd_idx <= scan_cnt[IDX_W-1:0];
        if (hit && !m_found) begin
          m_found <= 1'b1;
          m_idx   <= rd_idx;
          m_cnt   <= rd_entry.count;
        end
        if (rd_pend && !rd_valid && !i_found) begin
          i_found <= 1'b1;
          i_idx   <= rd_idx;
        end
        if (rd_pend && rd_valid && rd_entry.count == spill && !s_found) begin
          s_found <= 1'b1;
          s_idx   <= rd_idx;
        end
      end
      S_DECIDE: begin
        slot_q <= slot_sel;
        n_q    <= n_next;
      end
      S_MUL: begin
        prod_q <= PROD_W'(n_q[COUNT_W-1:1]) * PROD_W'(BONUS_RECIP);
      end
      S_BONUS: begin
        newc_q <= newc_next;
      end
      S_CHECK: begin
        if (div_rsp.done) begin
          mit_q <= (div_rsp.remainder == '0) && (newc_q >= COUNT_W'(threshold));
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_mitigate <= mit_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign access.ready    = (state == S_IDLE);
  assign result.valid    = out_valid;
  assign result.mitigate = out_mitigate;

endmodule

FILE: hw/rtl/rahh_checker.sv
module rahh_checker (
  input logic clk,
  input logic rst,
  input logic access_valid,
  input logic access_ready,
  input logic result_valid,
  input logic result_ready,
  input logic result_mitigate,
  input logic cfg_we
);

  // A waiting result keeps its value until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_mitigate))
    else $error("result changed or vanished while stalled");

  // One item at a time: the cycle after a transfer takes nothing new.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    access_valid && access_ready |=> !access_ready)
    else $error("input accepted while an item is in flight");

  // A fresh result only follows a cycle in which the block was busy.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(access_ready))
    else $error("result appeared without work in progress");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid straight after reset");

  // A register write only comes while the block is idle with no result waiting.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> access_ready && !result_valid)
    else $error("configuration write while an item is in flight");

endmodule

bind row_activation_heavy_hitter_tracker_top rahh_checker u_rahh_checker (
  .clk             (clk),
  .rst             (rst),
  .access_valid    (access.valid),
  .access_ready    (access.ready),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .result_mitigate (result.mitigate),
  .cfg_we          (cfg_we)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rahh_pkg::*;

  localparam int BONUS_FACTOR = 2;
  localparam int POOL_SIZE    = 120;
  localparam int TAIL_CYCLES  = 200;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [THR_W-1:0] cfg_wdata;

  rahh_access_if acc_if ();
  rahh_result_if res_if ();

  row_activation_heavy_hitter_tracker_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .access    (acc_if),
    .result    (res_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the tracker table, updated at every accepted transfer.
  logic               trk_valid [TABLE_DEPTH];
  logic [ROW_W-1:0]   trk_row   [TABLE_DEPTH];
  logic [COUNT_W-1:0] trk_count [TABLE_DEPTH];
  logic [COUNT_W-1:0] spill_shadow;
  logic [THR_W-1:0]   thr_setting;

  bit               mitigate_pending_q [$];
  logic [ROW_W-1:0] row_pool [POOL_SIZE];
  bit               predicted_mitigate;

  int sender_idle_pct;
  int stall_pct;
  int error_count;
  int items_sent;
  int window_resets_sent;
  int results_seen;
  int mitigations_seen;
  int thr_writes;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > COUNT_MAX) ? COUNT_MAX : s[COUNT_W-1:0];
  endfunction

  function automatic void clear_tracker();
    foreach (trk_valid[i]) begin
      trk_valid[i] = 1'b0;
      trk_row[i]   = '0;
      trk_count[i] = '0;
    end
    spill_shadow = '0;
  endfunction

  // Returns the predicted mitigate flag and moves the shadow table on by one item.
  function automatic bit track_access(input logic op, input logic [ROW_W-1:0] row);
    int                 slot;
    logic [COUNT_W-1:0] n;
    slot = -1;
    if (op == OP_WINDOW_RESET) begin
      clear_tracker();
      return 1'b0;
    end
    for (int i = 0; i < TABLE_DEPTH && slot < 0; i++) begin
      if (trk_valid[i] && trk_row[i] == row) slot = i;
    end
    for (int i = 0; i < TABLE_DEPTH && slot < 0; i++) begin
      if (!trk_valid[i]) begin
        slot         = i;
        trk_valid[i] = 1'b1;
        trk_row[i]   = row;
      end
    end
    // Misra-Gries replacement: only an entry that has fallen to the spillover level goes.
    for (int i = 0; i < TABLE_DEPTH && slot < 0; i++) begin
      if (trk_valid[i] && trk_count[i] == spill_shadow) begin
        slot       = i;
        trk_row[i] = row;
      end
    end
    if (slot < 0) begin
      spill_shadow = sat_add(spill_shadow, 1);
      return 1'b0;
    end
    n = sat_add(trk_count[slot], 1);
    n = sat_add(n, BONUS_FACTOR * (n / BONUS_DIVISOR));
    trk_count[slot] = n;
    return (thr_setting != 0) && (n >= thr_setting) && (n % thr_setting == 0);
  endfunction

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      results_seen++;
      if (mitigate_pending_q.size() == 0) begin
        report_mismatch("result transfer with no access outstanding");
      end else begin
        predicted_mitigate = mitigate_pending_q.pop_front();
        if (res_if.mitigate !== predicted_mitigate) begin
          report_mismatch($sformatf("mitigate was %0b, predicted %0b",
                                    res_if.mitigate, predicted_mitigate));
        end
        if (predicted_mitigate) mitigations_seen++;
      end
    end
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Leaves valid high after a transfer so that the next item can follow directly.
  task automatic send_item(input logic op, input logic [ROW_W-1:0] row);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      acc_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    acc_if.valid     <= 1'b1;
    acc_if.operation <= op;
    acc_if.row_addr  <= row;
    do @(posedge clk); while (!acc_if.ready);
    mitigate_pending_q.push_back(track_access(op, row));
    items_sent++;
    if (op == OP_WINDOW_RESET) window_resets_sent++;
  endtask

  task automatic settle_tracker();
    acc_if.valid <= 1'b0;
    while (mitigate_pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    settle_tracker();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    thr_setting  = value;
    thr_writes++;
  endtask

  task automatic test_default_threshold();
    send_item(OP_ACCESS, '0);
    send_item(OP_ACCESS, '1);
    send_item(OP_ACCESS, '0);
    send_item(OP_WINDOW_RESET, '1);
  endtask

  task automatic test_threshold_one();
    write_threshold(16'd1);
    send_item(OP_ACCESS, '1);
    send_item(OP_ACCESS, '0);
    send_item(OP_WINDOW_RESET, '0);
    send_item(OP_ACCESS, 32'hA5A5_A5A5);
    send_item(OP_ACCESS, 32'h5A5A_5A5A);
  endtask

  task automatic test_zero_threshold();
    write_threshold('0);
    repeat (4) send_item(OP_ACCESS, 32'h0000_1234);
    send_item(OP_ACCESS, 32'hFFFF_0000);
  endtask

  task automatic test_threshold_max();
    write_threshold('1);
    send_item(OP_ACCESS, 32'h0000_FFFF);
    send_item(OP_ACCESS, 32'h8000_0001);
    send_item(OP_WINDOW_RESET, 32'h7FFF_FFFE);
  endtask

  // Hammers one row well into the range where the proportional bonus grows; with a
  // threshold of 3 the count lands on a multiple every so often.
  task automatic test_hot_row();
    sender_idle_pct = 20;
    stall_pct       = 20;
    write_threshold(16'd3);
    send_item(OP_WINDOW_RESET, '0);
    repeat (100) send_item(OP_ACCESS, 32'hC0DE_0042);
    send_item(OP_ACCESS, 32'h0BAD_F00D);
  endtask

  // Two fifths of the traffic go to eight hot rows; the rest spreads over more rows than the
  // table holds, so that installs, replacements and spillover all occur.
  task automatic test_random(input int idle_pct, input int stall, input logic [THR_W-1:0] thr,
                             input int count);
    logic [ROW_W-1:0] row;
    int               pick;
    write_threshold(thr);
    sender_idle_pct = idle_pct;
    stall_pct       = stall;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(299);
      if (pick < 2) begin
        send_item(OP_WINDOW_RESET, $urandom());
      end else begin
        if (pick < 30) row = $urandom();
        else if (pick < 150) row = row_pool[$urandom_range(7)];
        else row = row_pool[$urandom_range(POOL_SIZE - 1)];
        send_item(OP_ACCESS, row);
      end
      if ($urandom_range(59) == 0) settle_tracker();
    end
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    acc_if.valid     <= 1'b0;
    acc_if.operation <= OP_ACCESS;
    acc_if.row_addr  <= '0;
    sender_idle_pct   = 0;
    stall_pct         = 0;
    thr_setting       = THR_RESET;
    clear_tracker();
    foreach (row_pool[i]) row_pool[i] = $urandom();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_default_threshold();
    test_threshold_one();
    test_zero_threshold();
    test_threshold_max();
    test_hot_row();
    test_random(0, 0, 16'd5, 83);
    test_random(81, 0, 16'd2, 83);
    test_random(0, 81, 16'd11, 83);
    test_random(20, 20, 16'($urandom_range(3, 40)), 83);

    settle_tracker();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d items (%0d window resets) over %0d threshold settings.",
             items_sent, window_resets_sent, thr_writes);
    $display("Checked %0d results, %0d of them with mitigation; %0d mismatches.",
             results_seen, mitigations_seen, error_count);
    if (error_count == 0) begin
      $display("row_activation_heavy_hitter_tracker_top test passed");
    end else begin
      $display("row_activation_heavy_hitter_tracker_top test failed");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Timed out with %0d results outstanding.", mitigate_pending_q.size());
    $display("row_activation_heavy_hitter_tracker_top test failed");
    $finish;
  end

endmodule
